// ===== hdl/cpr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared constants, state encoding and control/status bundles for the clock
// page replacement unit.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 20;

  localparam int CFG_W   = 4;
  localparam int FRAME_W = 3;
  localparam int TOTAL_W = 32;

  localparam logic [CFG_W-1:0] FRAMES_USED_RST = 4'd3;

  // fault + frame + evicted_valid + fault_total, page field comes on top
  localparam int RES_FIXED_W = 1 + FRAME_W + 1 + TOTAL_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EVICT,
    ST_COMMIT
  } cpr_state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic drain;
    logic evict;
    logic commit;
  } cpr_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
    logic out_free;
  } cpr_stat_t;

endpackage

// ===== hdl/cpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpr_ctrl
// Sequencer for one page reference: frame scan, eviction read and commit.
// ----------------------------------------------------------------------------
module cpr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  cpr_pkg::cpr_stat_t stat,
  output cpr_pkg::cpr_cmd_t  cmd
);

  cpr_pkg::cpr_state_t state;
  cpr_pkg::cpr_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cpr_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = cpr_pkg::ST_SCAN;
        end
      end
      cpr_pkg::ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = cpr_pkg::ST_DRAIN;
        end
      end
      cpr_pkg::ST_DRAIN: begin
        state_next = cpr_pkg::ST_EVICT;
      end
      cpr_pkg::ST_EVICT: begin
        state_next = cpr_pkg::ST_COMMIT;
      end
      cpr_pkg::ST_COMMIT: begin
        if (stat.out_free) begin
          state_next = cpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cpr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      cpr_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        cmd.start = s_tvalid;
      end
      cpr_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      cpr_pkg::ST_DRAIN: begin
        cmd.drain = 1'b1;
      end
      cpr_pkg::ST_EVICT: begin
        cmd.evict = !stat.found;
      end
      cpr_pkg::ST_COMMIT: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hdl/cpr_datapath.sv =====
// ----------------------------------------------------------------------------
// cpr_datapath
// Frame page memory, valid and reference bits, clock hand walk, fault count
// and the result register.
// ----------------------------------------------------------------------------
module cpr_datapath #(
  parameter int MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = cpr_pkg::PAGE_BITS_DEF,
  parameter int OUT_W      = ((cpr_pkg::RES_FIXED_W + PAGE_BITS + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cpr_pkg::cpr_cmd_t           cmd,
  output cpr_pkg::cpr_stat_t          stat,
  input  logic                        cfg_we,
  input  logic [cpr_pkg::CFG_W-1:0]   cfg_data,
  input  logic [PAGE_BITS-1:0]        page_in,
  input  logic                        m_tready,
  output logic                        m_tvalid,
  output logic [OUT_W-1:0]            m_tdata
);

  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int SW = CW + 1;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] cur,
                                              input logic [CW-1:0] n);
    logic [SW-1:0] nx;
    begin
      nx = SW'(cur) + SW'(1);
      next_slot = (nx >= SW'(n)) ? '0 : IW'(nx);
    end
  endfunction

  logic [cpr_pkg::CFG_W-1:0]   frames_used;
  logic [CW-1:0]               n_act;

  logic [PAGE_BITS-1:0]        mem [MAX_FRAMES];
  logic [PAGE_BITS-1:0]        rd_data;
  logic [IW-1:0]               rd_addr;
  logic                        rd_en;

  logic [PAGE_BITS-1:0]        page_reg;
  logic [IW-1:0]               scan_addr;
  logic [IW-1:0]               cmp_idx;
  logic                        cmp_pending;
  logic                        found;
  logic [IW-1:0]               hit_idx;
  logic                        hit_now;

  logic                        busy;
  logic [IW-1:0]               wpos;
  logic [CW-1:0]               wcnt;
  logic [MAX_FRAMES-1:0]       visited;
  logic                        walk_step;

  logic [MAX_FRAMES-1:0]       frame_valid;
  logic [MAX_FRAMES-1:0]       ref_bit;
  logic [MAX_FRAMES-1:0]       ref_bit_next;
  logic [IW-1:0]               hand;
  logic [cpr_pkg::TOTAL_W-1:0] counter;
  logic [cpr_pkg::TOTAL_W-1:0] counter_next;

  logic                        res_fault;
  logic [cpr_pkg::FRAME_W-1:0] res_frame;
  logic                        res_evv;
  logic [PAGE_BITS-1:0]        res_evp;
  logic [cpr_pkg::TOTAL_W-1:0] res_total;

  // active frame count, clamped to 1..MAX_FRAMES
  always_comb begin
    if (frames_used == '0) begin
      n_act = CW'(1);
    end else if (int'(frames_used) > MAX_FRAMES) begin
      n_act = CW'(MAX_FRAMES);
    end else begin
      n_act = CW'(frames_used);
    end
  end

  assign rd_en   = cmd.scan || cmd.evict;
  assign rd_addr = cmd.evict ? wpos : scan_addr;
  assign hit_now = cmp_pending && frame_valid[cmp_idx] && (rd_data == page_reg);
  assign walk_step = busy && ref_bit[wpos] && (wcnt != n_act);
  assign counter_next = (counter == '1) ? counter : counter + cpr_pkg::TOTAL_W'(1);

  assign stat.scan_last = (SW'(scan_addr) + SW'(1)) == SW'(n_act);
  assign stat.found     = found;
  assign stat.out_free  = !m_tvalid || m_tready;

  always_comb begin
    ref_bit_next = ref_bit;
    if (cmd.commit) begin
      if (found) begin
        ref_bit_next[hit_idx] = 1'b1;
      end else begin
        ref_bit_next = ref_bit & ~visited;
        ref_bit_next[wpos] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.commit && !found) begin
      mem[wpos] <= page_reg;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_used <= cpr_pkg::FRAMES_USED_RST;
      busy        <= 1'b0;
      cmp_pending <= 1'b0;
      found       <= 1'b0;
      visited     <= '0;
      frame_valid <= '0;
      ref_bit     <= '0;
      hand        <= '0;
      counter     <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        frames_used <= cfg_data;
      end
      ref_bit <= ref_bit_next;
      if (cmd.start) begin
        busy        <= 1'b1;
        cmp_pending <= 1'b0;
        found       <= 1'b0;
        visited     <= '0;
      end else begin
        if (cmd.scan) begin
          cmp_pending <= 1'b1;
        end else if (cmd.drain) begin
          cmp_pending <= 1'b0;
        end
        if (hit_now && !found) begin
          found <= 1'b1;
        end
        if (walk_step) begin
          visited[wpos] <= 1'b1;
        end
        if (cmd.commit) begin
          busy <= 1'b0;
          if (!found) begin
            frame_valid[wpos] <= 1'b1;
            hand              <= wpos;
            counter           <= counter_next;
          end
        end
      end
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      page_reg  <= page_in;
      scan_addr <= '0;
      wpos      <= next_slot(hand, n_act);
      wcnt      <= '0;
    end else begin
      if (cmd.scan) begin
        cmp_idx   <= scan_addr;
        scan_addr <= scan_addr + IW'(1);
      end
      if (hit_now && !found) begin
        hit_idx <= cmp_idx;
      end
      if (walk_step) begin
        wpos <= next_slot(wpos, n_act);
        wcnt <= wcnt + CW'(1);
      end
    end
    if (cmd.commit) begin
      if (found) begin
        res_fault <= 1'b0;
        res_frame <= cpr_pkg::FRAME_W'(hit_idx);
        res_evv   <= 1'b0;
        res_evp   <= '0;
        res_total <= counter;
      end else begin
        res_fault <= 1'b1;
        res_frame <= cpr_pkg::FRAME_W'(wpos);
        res_evv   <= frame_valid[wpos];
        res_evp   <= frame_valid[wpos] ? rd_data : '0;
        res_total <= counter_next;
      end
    end
  end

  assign m_tdata = OUT_W'({res_total, res_evp, res_evv, res_frame, res_fault});

endmodule

// ===== hdl/clock_page_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// clock_page_replacement_unit
// Second-chance (clock) page replacement over a set of frames; one result
// per page reference.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    s_tdata: page
//  m_*      out  m_tvalid/m_tready    m_tdata: fault, frame, evicted_valid,
//                                              evicted_page, fault_total
//  cfg_*    in   cfg_valid/cfg_ready  cfg_data: frames_used
//
// one reference is in progress at a time; the next is accepted after commit.
// the frame page memory has one read port and is scanned one frame per
// cycle over the active frames; the hand walk runs alongside the scan.
// reset clears valid and reference bits, hand, fault count; frames_used
// returns to 3. no clearing pass.
// a stalled result stays in the output register; the next reference is
// taken meanwhile and waits at commit until that register is free.
// ----------------------------------------------------------------------------
module clock_page_replacement_unit #(
  parameter int MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = cpr_pkg::PAGE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [((PAGE_BITS+7)/8)*8-1:0] s_tdata,  // page
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // fault, frame, evicted_valid, evicted_page, fault_total
  output logic [((cpr_pkg::RES_FIXED_W+PAGE_BITS+7)/8)*8-1:0] m_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cpr_pkg::CFG_W-1:0]  cfg_data
);

  localparam int OUT_W = ((cpr_pkg::RES_FIXED_W + PAGE_BITS + 7) / 8) * 8;

  cpr_pkg::cpr_cmd_t  cmd;
  cpr_pkg::cpr_stat_t stat;

  assign cfg_ready = 1'b1;

  cpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cpr_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .OUT_W      (OUT_W)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .page_in  (s_tdata[PAGE_BITS-1:0]),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("reference accepted while another is in progress");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("commit did not load the result register");

  a_commit_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> s_tready)
    else $error("controller not ready after commit");

  a_no_commit_over_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !cmd.commit)
    else $error("commit over a result not yet taken");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for clock_page_replacement_unit. A short directed table
// of page references and frame-count writes comes first, followed by random
// phases that draw mostly from a small working set so that hits, second-chance
// sweeps and evictions all occur. Each transaction is predicted by a
// second-chance model kept in the bench, or taken from the table for typed
// rows, and compared field by field. Phases vary source gaps and sink
// stalls, and one phase holds the sink off long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cpr_pkg::*;

  localparam int PAGE_W          = PAGE_BITS_DEF;
  localparam int NFRAMES         = MAX_FRAMES_DEF;
  localparam int S_W             = ((PAGE_W + 7) / 8) * 8;
  localparam int M_W             = ((RES_FIXED_W + PAGE_W + 7) / 8) * 8;
  localparam int SETTLE_CYCLES   = NFRAMES + 4;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_CYCLES     = 400;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 240;

  // fields from the lowest bit up: fault, frame, evicted_valid, evicted_page, fault_total
  typedef struct packed {
    logic [TOTAL_W-1:0] fault_total;
    logic [PAGE_W-1:0]  evicted_page;
    logic               evicted_valid;
    logic [FRAME_W-1:0] frame;
    logic               fault;
  } lookup_result_t;

  typedef enum bit {ROW_PAGE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [PAGE_W-1:0] value;
    bit                typed;
    bit                fault;
    int                frame;
    bit                ev_valid;
    logic [PAGE_W-1:0] ev_page;
    int                total;
  } stim_row_t;

  // kind, page or frame count, typed, fault, frame, evicted_valid, evicted_page, total
  stim_row_t dir_rows [28] = '{
    '{ROW_PAGE, 20'h00000, 1, 1, 1, 0, 20'h00000, 1},
    '{ROW_PAGE, 20'hfffff, 1, 1, 2, 0, 20'h00000, 2},
    '{ROW_PAGE, 20'h00000, 1, 0, 1, 0, 20'h00000, 2},
    '{ROW_PAGE, 20'h00005, 1, 1, 0, 0, 20'h00000, 3},
    '{ROW_PAGE, 20'h00007, 1, 1, 2, 1, 20'hfffff, 4},
    '{ROW_PAGE, 20'h00000, 1, 0, 1, 0, 20'h00000, 4},
    '{ROW_PAGE, 20'h00005, 1, 0, 0, 0, 20'h00000, 4},
    '{ROW_PAGE, 20'h00007, 1, 0, 2, 0, 20'h00000, 4},
    // every reference bit set: the sweep clears all and comes back around
    '{ROW_PAGE, 20'h00009, 1, 1, 0, 1, 20'h00005, 5},
    '{ROW_CFG,  20'd8,     0, 0, 0, 0, 20'h00000, 0},
    '{ROW_PAGE, 20'haaaaa, 0, 0, 0, 0, 20'h00000, 0},
    '{ROW_PAGE, 20'h55555, 0, 0, 0, 0, 20'h00000, 0},
    '{ROW_PAGE, 20'h00000, 0, 0, 0, 0, 20'h00000, 0},
    '{ROW_PAGE, 20'hfffff, 0, 0, 0, 0, 20'h00000, 0},
    '{ROW_CFG,  20'd1,     0, 0, 0, 0, 20'h00000, 0},
    '{ROW_PAGE, 20'h00000, 0, 0, 0, 0, 20'h00000, 0},
    '{ROW_PAGE, 20'h00003, 0, 0, 0, 0, 20'h00000, 0},
    // zero frame count acts as one
    '{ROW_CFG,  20'd0,     0, 0, 0, 0, 20'h00000, 0},
    '{ROW_PAGE, 20'h00003, 0, 0, 0, 0, 20'h00000, 0},
    '{ROW_PAGE, 20'hfffff, 0, 0, 0, 0, 20'h00000, 0},
    // above the frame limit acts as the limit
    '{ROW_CFG,  20'd15,    0, 0, 0, 0, 20'h00000, 0},
    '{ROW_PAGE, 20'h12345, 0, 0, 0, 0, 20'h00000, 0},
    '{ROW_PAGE, 20'h00009, 0, 0, 0, 0, 20'h00000, 0},
    // shrink while the hand sits beyond the new count
    '{ROW_CFG,  20'd2,     0, 0, 0, 0, 20'h00000, 0},
    '{ROW_PAGE, 20'h00000, 0, 0, 0, 0, 20'h00000, 0},
    '{ROW_PAGE, 20'h00006, 0, 0, 0, 0, 20'h00000, 0},
    '{ROW_CFG,  20'd3,     0, 0, 0, 0, 20'h00000, 0},
    '{ROW_PAGE, 20'h00009, 0, 0, 0, 0, 20'h00000, 0}
  };

  logic [CFG_W-1:0] phase_frames [RAND_PHASES] = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd5, 4'd2, 4'd7, 4'd4};
  int send_idle_by_mode [4] = '{0, 62, 0, 33};
  int stall_by_mode     [4] = '{0, 0, 62, 33};

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [S_W-1:0]   s_tdata = '0;    // page
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [M_W-1:0]   m_tdata;         // fault, frame, evicted_valid, evicted_page, fault_total
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  // bench copy of the replacement state
  logic [PAGE_W-1:0]  resident_page  [NFRAMES];
  bit                 resident_valid [NFRAMES];
  bit                 second_chance  [NFRAMES];
  int unsigned        clock_hand;
  logic [TOTAL_W-1:0] faults_seen;
  logic [CFG_W-1:0]   frames_cfg;
  lookup_result_t     expected_results [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_trigger  = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int mismatches    = 0;
  int pages_sent    = 0;
  int results_seen  = 0;
  int faults_out    = 0;
  int cfg_writes    = 0;

  always #10 clk = ~clk;

  clock_page_replacement_unit #(
    .MAX_FRAMES(NFRAMES),
    .PAGE_BITS (PAGE_W)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  function automatic lookup_result_t reference_page(input logic [PAGE_W-1:0] pg);
    lookup_result_t r;
    int unsigned n;
    int unsigned pos;
    int unsigned guard;
    int unsigned i;
    r = '0;
    n = (frames_cfg == 0) ? 1 : (frames_cfg > NFRAMES) ? NFRAMES : frames_cfg;
    for (i = 0; i < n; i++) begin
      if (resident_valid[i] && resident_page[i] == pg) begin
        second_chance[i] = 1'b1;
        r.frame = FRAME_W'(i);
        r.fault_total = faults_seen;
        return r;
      end
    end
    pos = (clock_hand + 1 >= n) ? 0 : clock_hand + 1;
    guard = 0;
    while (second_chance[pos] && guard <= n) begin
      second_chance[pos] = 1'b0;
      pos = (pos + 1 >= n) ? 0 : pos + 1;
      guard++;
    end
    clock_hand = pos;
    if (resident_valid[pos]) begin
      r.evicted_valid = 1'b1;
      r.evicted_page = resident_page[pos];
    end
    resident_page[pos] = pg;
    resident_valid[pos] = 1'b1;
    second_chance[pos] = 1'b0;
    if (faults_seen != '1) faults_seen++;
    r.fault = 1'b1;
    r.frame = FRAME_W'(pos);
    r.fault_total = faults_seen;
    return r;
  endfunction

  task automatic offer_page(input logic [PAGE_W-1:0] pg, input bit typed,
                            input lookup_result_t typed_want);
    lookup_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= S_W'(pg);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = reference_page(pg);
    expected_results.push_back(typed ? typed_want : predicted);
    pages_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frames_used(input logic [CFG_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    frames_cfg = value;
    cfg_writes++;
  endtask

  task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                             input logic [TOTAL_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // sink ready: random stalls, plus one long hold when requested
  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[RES_FIXED_W+PAGE_W-1:0];
      results_seen++;
      if (got.fault) faults_out++;
      if (expected_results.size() == 0) begin
        $error("unexpected transaction: fault=%0d frame=%0d total=%0d",
               got.fault, got.frame, got.fault_total);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("fault", TOTAL_W'(want.fault), TOTAL_W'(got.fault));
        check_field("frame", TOTAL_W'(want.frame), TOTAL_W'(got.frame));
        check_field("evicted_valid", TOTAL_W'(want.evicted_valid), TOTAL_W'(got.evicted_valid));
        check_field("evicted_page", TOTAL_W'(want.evicted_page), TOTAL_W'(got.evicted_page));
        check_field("fault_total", want.fault_total, got.fault_total);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int k;
    int ph;
    int r;
    int pool_size;
    logic [PAGE_W-1:0] pg;
    logic [PAGE_W-1:0] pool [$];
    lookup_result_t typed_want;
    for (k = 0; k < NFRAMES; k++) begin
      resident_page[k] = '0;
      resident_valid[k] = 1'b0;
      second_chance[k] = 1'b0;
    end
    clock_hand = 0;
    faults_seen = '0;
    frames_cfg = FRAMES_USED_RST;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        write_frames_used(dir_rows[k].value[CFG_W-1:0]);
      end else begin
        typed_want.fault = dir_rows[k].fault;
        typed_want.frame = FRAME_W'(dir_rows[k].frame);
        typed_want.evicted_valid = dir_rows[k].ev_valid;
        typed_want.evicted_page = dir_rows[k].ev_page;
        typed_want.fault_total = TOTAL_W'(dir_rows[k].total);
        offer_page(dir_rows[k].value, dir_rows[k].typed, typed_want);
      end
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      write_frames_used(ph == RAND_PHASES - 1 ? CFG_W'($urandom_range(15)) : phase_frames[ph]);
      send_idle_pct = send_idle_by_mode[ph % 4];
      stall_pct = stall_by_mode[ph % 4];
      if (ph == 4) hold_trigger++;
      pool.delete();
      pool_size = $urandom_range(12, 2);
      repeat (pool_size) pool.push_back(PAGE_W'($urandom));
      repeat (ITEMS_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 75) pg = pool[$urandom_range(pool.size() - 1)];
        else if (r < 92) pg = PAGE_W'($urandom);
        else pg = $urandom_range(1) ? '1 : '0;
        offer_page(pg, 1'b0, '0);
      end
    end

    settle();
    $display("covered %0d page references, %0d faults among %0d results", pages_sent,
             faults_out, results_seen);
    $display("across %0d frame-count writes with mixed source gaps and sink stalls", cfg_writes);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cpr_pkg.sv
hdl/cpr_ctrl.sv
hdl/cpr_datapath.sv
hdl/clock_page_replacement_unit.sv
tb/testbench.sv
